>>> design/tems_pkg.sv
// Types and constants shared by the timed event scheduler.
// No dependencies.
package tems_pkg;

	localparam int TICK_W = 48;
	localparam int TAG_W  = 16;
	localparam int SLOT_W = 4;
	localparam int AMT_W  = 32;
	localparam int CMD_W  = 3;
	localparam int SLOTS  = 16;
	localparam int RESULT_LIMIT = 64;
	localparam int NCNT_W = $clog2(RESULT_LIMIT + 1);

	localparam logic [CMD_W-1:0] CMD_SCHED    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_QUANT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DRAIN    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DEAD = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef struct packed {
		logic [TICK_W-1:0] tick;
		logic [TAG_W-1:0]  tag;
		logic              has;
		logic [SLOT_W-1:0] slot;
	} entry_t;

	typedef struct packed {
		logic [1:0] status;
		logic       ev;
		entry_t     ent;
		logic       last;
	} res_t;

	function automatic res_t mk_res(logic [1:0] st, logic ev, entry_t e, logic lst);
		res_t r;
		r.status = st;
		r.ev     = ev;
		r.ent    = ev ? e : '0;
		r.last   = lst;
		return r;
	endfunction

endpackage

>>> design/timed_event_min_heap_scheduler_top.sv
// Timed event scheduler: binary min-heap on due tick in a single-port-write RAM,
// walked by one compare unit; restoring divider for period quantisation. Uses tems_pkg.
// Schedule climbs the heap from the new leaf, one parent compare per level; a quantised
// schedule with a nonzero period first runs the divider, one remainder bit per cycle
// over the 48-bit position. Drain pops due events one at a time, sifting the last entry
// down from the root after each pop.
// One request at a time (busy high while working); results are one-cycle strobes
// and cannot be stalled. Async reset empties the heap and clears task flags and position.
module timed_event_min_heap_scheduler_top #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tems_pkg::CMD_W-1:0]   cmd,
	input  logic [tems_pkg::TICK_W-1:0]  base_tick,
	input  logic [tems_pkg::AMT_W-1:0]   amount,
	input  logic [tems_pkg::TAG_W-1:0]   tag,
	input  logic [tems_pkg::SLOT_W-1:0]  task_id,
	input  logic                         has_task,
	output logic                         result_valid,
	output logic [1:0]                   status,
	output logic                         event_valid,
	output logic [tems_pkg::TICK_W-1:0]  event_tick,
	output logic [tems_pkg::TAG_W-1:0]   event_tag,
	output logic [tems_pkg::SLOT_W-1:0]  event_task,
	output logic                         event_has_task,
	output logic [tems_pkg::TICK_W-1:0]  position,
	output logic                         last
);
	import tems_pkg::*;

	localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = IW + 2;
	localparam int DCW = $clog2(TICK_W);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_DIV    = 14'b00000000000010,
		S_QEND   = 14'b00000000000100,
		S_PUSH   = 14'b00000000001000,
		S_UP     = 14'b00000000010000,
		S_UPCMP  = 14'b00000000100000,
		S_DR     = 14'b00000001000000,
		S_DRCHK  = 14'b00000010000000,
		S_DNLOAD = 14'b00000100000000,
		S_DNL    = 14'b00001000000000,
		S_DNR    = 14'b00010000000000,
		S_DNCMP  = 14'b00100000000000,
		S_DREMIT = 14'b01000000000000,
		S_DREND  = 14'b10000000000000
	} state_t;

	state_t              state_q;
	entry_t              mem_q [HEAP_DEPTH];
	entry_t              rd_q;
	entry_t              cur_q, lv_q, pop_q, pend_q;
	logic                pend_v_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       i_q;
	logic [TICK_W-1:0]   pos_q;
	logic [SLOTS-1:0]    canc_q, comp_q;
	logic [NCNT_W-1:0]   n_q;
	logic [AMT_W:0]      rem_q;
	logic [TICK_W-1:0]   dq_q;
	logic [AMT_W-1:0]    amt_q;
	logic [DCW-1:0]      dcnt_q;
	res_t                res_q;
	logic                res_v_q;

	logic                we;
	logic [IW-1:0]       wa, ra;
	entry_t              wd;
	logic [XW-1:0]       l_x, r_x, cnt_x;
	logic [IW-1:0]       par;
	logic                lt_up, lt_l, r_ok, s_r;
	logic [TICK_W-1:0]   smin;
	logic [AMT_W:0]      trial;
	logic [AMT_W-1:0]    dly;

	assign l_x   = {1'b0, i_q, 1'b1};
	assign r_x   = {1'b0, i_q, 1'b0} + XW'(2);
	assign cnt_x = XW'(count_q);
	assign par   = IW'((i_q - IW'(1)) >> 1);
	assign lt_up = cur_q.tick < rd_q.tick;
	assign lt_l  = lv_q.tick < cur_q.tick;
	assign smin  = lt_l ? lv_q.tick : cur_q.tick;
	assign r_ok  = r_x < cnt_x;
	assign s_r   = r_ok && (rd_q.tick < smin);
	assign trial = {rem_q[AMT_W-1:0], dq_q[TICK_W-1]};
	assign dly   = (rem_q[AMT_W-1:0] == '0) ? amt_q : amt_q - rem_q[AMT_W-1:0];

	// heap RAM port control
	always_comb begin
		we = 1'b0;
		wa = i_q;
		wd = cur_q;
		ra = '0;
		case (state_q)
			S_UP: begin
				if (i_q == '0) we = 1'b1;
				else ra = par;
			end
			S_UPCMP: begin
				we = 1'b1;
				wd = lt_up ? rd_q : cur_q;
			end
			S_DRCHK: ra = IW'(count_q - CW'(1));
			S_DNL: begin
				if (l_x >= cnt_x) we = 1'b1;
				else ra = l_x[IW-1:0];
			end
			S_DNR: ra = r_x[IW-1:0];
			S_DNCMP: begin
				we = 1'b1;
				wd = s_r ? rd_q : (lt_l ? lv_q : cur_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			pos_q    <= '0;
			canc_q   <= '0;
			comp_q   <= '0;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
			n_q      <= '0;
			res_q    <= '0;
			cur_q    <= '0;
			lv_q     <= '0;
			pop_q    <= '0;
			pend_q   <= '0;
			i_q      <= '0;
			rem_q    <= '0;
			dq_q     <= '0;
			amt_q    <= '0;
			dcnt_q   <= '0;
		end else begin
			res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cur_q.tag  <= tag;
						cur_q.slot <= task_id;
						amt_q      <= amount;
						case (cmd)
							CMD_SCHED: begin
								cur_q.tick <= base_tick + TICK_W'(amount);
								cur_q.has  <= has_task;
								if (has_task && (canc_q[task_id] || comp_q[task_id])) begin
									res_q   <= mk_res(ST_DEAD, 1'b0, '0, 1'b1);
									res_v_q <= 1'b1;
								end else begin
									state_q <= S_PUSH;
								end
							end
							CMD_QUANT: begin
								canc_q[task_id] <= 1'b0;
								comp_q[task_id] <= 1'b0;
								cur_q.has       <= 1'b1;
								cur_q.tick      <= pos_q;
								rem_q           <= '0;
								dq_q            <= pos_q;
								dcnt_q          <= DCW'(TICK_W - 1);
								state_q         <= (amount == '0) ? S_PUSH : S_DIV;
							end
							CMD_ADVANCE: begin
								pos_q   <= pos_q + TICK_W'(amount);
								res_q   <= mk_res(ST_OK, 1'b0, '0, 1'b1);
								res_v_q <= 1'b1;
							end
							CMD_DRAIN: begin
								n_q      <= '0;
								pend_v_q <= 1'b0;
								state_q  <= S_DR;
							end
							CMD_CANCEL: begin
								canc_q[task_id] <= 1'b1;
								res_q   <= mk_res(ST_OK, 1'b0, '0, 1'b1);
								res_v_q <= 1'b1;
							end
							CMD_COMPLETE: begin
								comp_q[task_id] <= 1'b1;
								res_q   <= mk_res(ST_OK, 1'b0, '0, 1'b1);
								res_v_q <= 1'b1;
							end
							default: begin
								res_q   <= mk_res(ST_OK, 1'b0, '0, 1'b1);
								res_v_q <= 1'b1;
							end
						endcase
					end
				end
				S_DIV: begin
					rem_q  <= (trial >= {1'b0, amt_q}) ? trial - {1'b0, amt_q} : trial;
					dq_q   <= {dq_q[TICK_W-2:0], 1'b0};
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == '0) state_q <= S_QEND;
				end
				S_QEND: begin
					cur_q.tick <= pos_q + TICK_W'(dly);
					state_q    <= S_PUSH;
				end
				S_PUSH: begin
					if (count_q >= CW'(HEAP_DEPTH)) begin
						res_q   <= mk_res(ST_FULL, 1'b0, '0, 1'b1);
						res_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q     <= IW'(count_q);
						count_q <= count_q + CW'(1);
						state_q <= S_UP;
					end
				end
				S_UP: begin
					if (i_q == '0) begin
						res_q   <= mk_res(ST_OK, 1'b0, '0, 1'b1);
						res_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_UPCMP;
					end
				end
				S_UPCMP: begin
					if (lt_up) begin
						i_q     <= par;
						state_q <= S_UP;
					end else begin
						res_q   <= mk_res(ST_OK, 1'b0, '0, 1'b1);
						res_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DR: begin
					if (n_q == NCNT_W'(RESULT_LIMIT) || count_q == '0) state_q <= S_DREND;
					else state_q <= S_DRCHK;
				end
				S_DRCHK: begin
					if (rd_q.tick > pos_q) begin
						state_q <= S_DREND;
					end else begin
						pop_q   <= rd_q;
						count_q <= count_q - CW'(1);
						state_q <= (count_q == CW'(1)) ? S_DREMIT : S_DNLOAD;
					end
				end
				S_DNLOAD: begin
					cur_q   <= rd_q;
					i_q     <= '0;
					state_q <= S_DNL;
				end
				S_DNL: state_q <= (l_x >= cnt_x) ? S_DREMIT : S_DNR;
				S_DNR: begin
					lv_q    <= rd_q;
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (s_r) begin
						i_q     <= r_x[IW-1:0];
						state_q <= S_DNL;
					end else if (lt_l) begin
						i_q     <= l_x[IW-1:0];
						state_q <= S_DNL;
					end else begin
						state_q <= S_DREMIT;
					end
				end
				S_DREMIT: begin
					// events of dead tasks are dropped without a result
					if (!(pop_q.has && (canc_q[pop_q.slot] || comp_q[pop_q.slot]))) begin
						if (pend_v_q) begin
							res_q   <= mk_res(ST_OK, 1'b1, pend_q, 1'b0);
							res_v_q <= 1'b1;
						end
						pend_q   <= pop_q;
						pend_v_q <= 1'b1;
						n_q      <= n_q + NCNT_W'(1);
					end
					state_q <= S_DR;
				end
				S_DREND: begin
					res_q    <= pend_v_q ? mk_res(ST_OK, 1'b1, pend_q, 1'b1)
					                     : mk_res(ST_NONE, 1'b0, '0, 1'b1);
					res_v_q  <= 1'b1;
					pend_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign result_valid   = res_v_q;
	assign status         = res_q.status;
	assign event_valid    = res_q.ev;
	assign event_tick     = res_q.ent.tick;
	assign event_tag      = res_q.ent.tag;
	assign event_task     = res_q.ent.slot;
	assign event_has_task = res_q.ent.has;
	assign position       = pos_q;
	assign last           = res_q.last;

endmodule

>>> tb/sv/timed_event_min_heap_scheduler_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the timed event min-heap scheduler top level.
// Predicts every result with an in-bench heap model; depends on tems_pkg.
module timed_event_min_heap_scheduler_top_tb;
	import tems_pkg::*;

	localparam int DEPTH = 64;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [TICK_W-1:0] base;
		logic [AMT_W-1:0]  amt;
		logic [TAG_W-1:0]  tg;
		logic [SLOT_W-1:0] tid;
		logic              ht;
		bit                hold; // wait for all results before this request
	} request_t;

	typedef struct {
		logic [1:0]        st;
		logic              ev;
		logic [TICK_W-1:0] tick;
		logic [TAG_W-1:0]  tg;
		logic [SLOT_W-1:0] slot;
		logic              has;
		logic [TICK_W-1:0] pos;
		logic              lst;
	} outcome_t;

	logic clk = 0, arst_n = 0, start = 0;
	logic busy;
	logic [CMD_W-1:0]  cmd = '0;
	logic [TICK_W-1:0] base_tick = '0;
	logic [AMT_W-1:0]  amount = '0;
	logic [TAG_W-1:0]  tag = '0;
	logic [SLOT_W-1:0] task_id = '0;
	logic has_task = 0;
	logic result_valid, event_valid, event_has_task, last;
	logic [1:0] status;
	logic [TICK_W-1:0] event_tick, position;
	logic [TAG_W-1:0] event_tag;
	logic [SLOT_W-1:0] event_task;

	timed_event_min_heap_scheduler_top #(.HEAP_DEPTH(DEPTH)) dut (.*);

	// scheduler shadow state
	logic [TICK_W-1:0] h_tick [DEPTH];
	logic [TAG_W-1:0]  h_tag  [DEPTH];
	logic [4:0]        h_task [DEPTH];
	int                h_cnt;
	logic [TICK_W-1:0] now_pos;
	bit                killed [SLOTS];
	bit                done_f [SLOTS];

	request_t pending[$];
	outcome_t awaited[$];
	int  fails = 0;
	int  idle_pct = 0;
	bit  all_sent = 0;
	longint cycles = 0;

	function automatic void swap_slots(int a, int b);
		logic [TICK_W-1:0] t;
		logic [TAG_W-1:0] g;
		logic [4:0] k;
		t = h_tick[a]; g = h_tag[a]; k = h_task[a];
		h_tick[a] = h_tick[b]; h_tag[a] = h_tag[b]; h_task[a] = h_task[b];
		h_tick[b] = t; h_tag[b] = g; h_task[b] = k;
	endfunction

	function automatic logic [1:0] heap_insert(logic [TICK_W-1:0] t, logic [TAG_W-1:0] g,
			logic [4:0] k);
		int i, p;
		if (h_cnt >= DEPTH) return ST_FULL;
		h_tick[h_cnt] = t; h_tag[h_cnt] = g; h_task[h_cnt] = k;
		i = h_cnt;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (h_tick[i] < h_tick[p]) begin
				swap_slots(i, p);
				i = p;
			end else break;
		end
		h_cnt++;
		return ST_OK;
	endfunction

	task automatic heap_remove_top();
		int i, l, r, s;
		h_cnt--;
		if (h_cnt > 0) begin
			h_tick[0] = h_tick[h_cnt]; h_tag[0] = h_tag[h_cnt]; h_task[0] = h_task[h_cnt];
			i = 0;
			forever begin
				l = 2 * i + 1; r = 2 * i + 2; s = i;
				if (l < h_cnt && h_tick[l] < h_tick[s]) s = l;
				if (r < h_cnt && h_tick[r] < h_tick[s]) s = r;
				if (s == i) break;
				swap_slots(i, s);
				i = s;
			end
		end
	endtask

	function automatic outcome_t plain(logic [1:0] st);
		outcome_t o;
		o = '{st: st, ev: 0, tick: '0, tg: '0, slot: '0, has: 0, pos: now_pos, lst: 1};
		return o;
	endfunction

	task automatic predict_schedule(request_t q);
		logic [1:0] st;
		logic [TICK_W-1:0] delay, off;
		int n;
		outcome_t o;
		st = ST_OK;
		case (q.cmd)
			CMD_SCHED:
				if (q.ht && (killed[q.tid] || done_f[q.tid])) st = ST_DEAD;
				else st = heap_insert(q.base + q.amt, q.tg, {q.ht, q.tid});
			CMD_QUANT: begin
				killed[q.tid] = 0;
				done_f[q.tid] = 0;
				delay = '0;
				if (q.amt != 0) begin
					off = now_pos % q.amt;
					delay = (off == 0) ? q.amt : q.amt - off;
				end
				st = heap_insert(now_pos + delay, q.tg, {1'b1, q.tid});
			end
			CMD_ADVANCE: now_pos = now_pos + q.amt;
			CMD_DRAIN: begin
				n = 0;
				while (n < RESULT_LIMIT && h_cnt > 0 && h_tick[0] <= now_pos) begin
					o = '{st: ST_OK, ev: 1, tick: h_tick[0], tg: h_tag[0],
						slot: h_task[0][3:0], has: h_task[0][4], pos: now_pos, lst: 0};
					heap_remove_top();
					if (o.has && (killed[o.slot] || done_f[o.slot])) continue;
					awaited.push_back(o);
					n++;
				end
				if (n == 0) awaited.push_back(plain(ST_NONE));
				else awaited[$].lst = 1;
				return;
			end
			CMD_CANCEL:   killed[q.tid] = 1;
			CMD_COMPLETE: done_f[q.tid] = 1;
			default: ;
		endcase
		awaited.push_back(plain(st));
	endtask

	initial forever #10 clk = ~clk;

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!arst_n) begin
			start <= 0;
		end else begin
			if (start && !busy) predict_schedule(pending.pop_front());
			if (start && busy) begin
				// request still being offered
			end else if (pending.size() > 0 && !(pending[0].hold && awaited.size() > 0)
					&& !(start && !busy && pending[0].hold)
					&& $urandom_range(99) >= idle_pct) begin
				start     <= 1;
				cmd       <= pending[0].cmd;
				base_tick <= pending[0].base;
				amount    <= pending[0].amt;
				tag       <= pending[0].tg;
				task_id   <= pending[0].tid;
				has_task  <= pending[0].ht;
			end else begin
				start <= 0;
				if (pending.size() == 0 && !(start && busy)) all_sent <= 1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && result_valid) begin
			if (awaited.size() == 0) begin
				$error("result with nothing awaited");
				fails++;
			end else begin
				e = awaited.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); fails++;
				end
				if (event_valid !== e.ev) begin
					$error("event_valid exp %0d got %0d", e.ev, event_valid); fails++;
				end
				if (event_tick !== e.tick) begin
					$error("event_tick exp %0h got %0h", e.tick, event_tick); fails++;
				end
				if (event_tag !== e.tg) begin
					$error("event_tag exp %0h got %0h", e.tg, event_tag); fails++;
				end
				if (event_task !== e.slot) begin
					$error("event_task exp %0d got %0d", e.slot, event_task); fails++;
				end
				if (event_has_task !== e.has) begin
					$error("event_has_task exp %0d got %0d", e.has, event_has_task); fails++;
				end
				if (position !== e.pos) begin
					$error("position exp %0h got %0h", e.pos, position); fails++;
				end
				if (last !== e.lst) begin
					$error("last exp %0d got %0d", e.lst, last); fails++;
				end
			end
		end
	end

	function automatic request_t mk(logic [CMD_W-1:0] c, logic [TICK_W-1:0] b,
			logic [AMT_W-1:0] a, logic [TAG_W-1:0] g, logic [SLOT_W-1:0] t, logic h);
		request_t q;
		q = '{cmd: c, base: b, amt: a, tg: g, tid: t, ht: h, hold: 0};
		return q;
	endfunction

	function automatic longint now_guess();
		return longint'($urandom_range(2000));
	endfunction

	function automatic request_t rand_req();
		logic [CMD_W-1:0] c;
		int r;
		logic [AMT_W-1:0] a;
		r = $urandom_range(99);
		// mostly pushes with small base ticks, regular drains and small advances
		if (r < 40) c = CMD_SCHED;
		else if (r < 52) c = CMD_QUANT;
		else if (r < 67) c = CMD_ADVANCE;
		else if (r < 84) c = CMD_DRAIN;
		else if (r < 90) c = CMD_CANCEL;
		else if (r < 96) c = CMD_COMPLETE;
		else c = 3'(6 + $urandom_range(1));
		a = ($urandom_range(9) == 0) ? $urandom : AMT_W'($urandom_range(300));
		return mk(c, ($urandom_range(7) == 0) ? TICK_W'({$urandom, $urandom})
			: TICK_W'(now_guess()),
			a, TAG_W'($urandom), SLOT_W'($urandom), 1'($urandom_range(1)));
	endfunction

	initial begin
		request_t q;
		// directed: extremes, every command, special cases
		pending.push_back(mk(CMD_DRAIN, 0, 0, 0, 0, 0));             // empty drain
		pending.push_back(mk(CMD_SCHED, '1, '1, '1, 4'hF, 1));       // wrapping tick
		pending.push_back(mk(CMD_SCHED, 0, 0, 16'h1234, 3, 0));
		pending.push_back(mk(CMD_SCHED, 5, 0, 16'h0A0A, 3, 1));
		pending.push_back(mk(CMD_SCHED, 5, 0, 16'h0B0B, 2, 0));      // equal ticks
		pending.push_back(mk(CMD_QUANT, 0, 0, 16'hC0DE, 7, 0));      // zero period
		pending.push_back(mk(CMD_QUANT, 0, 10, 16'hC0DF, 8, 0));     // on boundary
		pending.push_back(mk(CMD_ADVANCE, 0, 7, 0, 0, 0));
		pending.push_back(mk(CMD_QUANT, 0, 4, 16'hC0E0, 9, 0));
		pending.push_back(mk(CMD_CANCEL, 0, 0, 0, 3, 0));
		pending.push_back(mk(CMD_SCHED, 1, 1, 16'hDEAD, 3, 1));      // dead task
		pending.push_back(mk(CMD_COMPLETE, 0, 0, 0, 9, 0));
		pending.push_back(mk(CMD_DRAIN, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_ADVANCE, 0, '1, 0, 0, 0));
		pending.push_back(mk(3'd6, 0, 0, 0, 0, 0));
		pending.push_back(mk(3'd7, '1, '1, '1, '1, 1));
		pending.push_back(mk(CMD_DRAIN, 0, 0, 0, 0, 0));
		// fill past capacity, then drain the lot
		for (int i = 0; i < DEPTH + 2; i++)
			pending.push_back(mk(CMD_SCHED, 0, AMT_W'($urandom_range(40)),
				TAG_W'($urandom), SLOT_W'($urandom), 0));
		pending.push_back(mk(CMD_DRAIN, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_DRAIN, 0, 0, 0, 0, 0));
		// random phases: no idling, sender mostly idle, mixed, then no idling again
		for (int i = 0; i < 125; i++) begin
			q = rand_req();
			if (i == 60) q.hold = 1;
			pending.push_back(q);
		end

		for (int i = 0; i < DEPTH; i++) begin
			h_tick[i] = '0; h_tag[i] = '0; h_task[i] = '0;
		end
		h_cnt = 0; now_pos = '0;
		foreach (killed[i]) begin killed[i] = 0; done_f[i] = 0; end

		repeat (3) @(posedge clk);
		arst_n <= 1;
		fork
			forever begin
				@(posedge clk);
				if (pending.size() < 140) idle_pct = 86;
				if (pending.size() < 70) idle_pct = 37;
				if (pending.size() < 30) idle_pct = 0;
			end
		join_none
		while (!(all_sent && awaited.size() == 0) && cycles < CYCLE_LIMIT) @(posedge clk);
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			repeat (3000) @(posedge clk);
			if (fails == 0 && awaited.size() == 0) $display("PASS");
			else $display("FAIL");
			$finish;
		end
	end
endmodule
